/* hw/rtl/cc1s_pkg.sv */
`default_nettype none
package cc1s_pkg;

	localparam int TAPS_DEF   = 4;
	localparam int SAMPLE_W   = 16;
	localparam int WIN_DEPTH  = 4;
	localparam int WIN_IW     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MUL_W      = 17;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int ACC_W      = 35;
	localparam int SIG_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TAP_OLDEST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_OLDER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_PREVIOUS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_CURRENT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_VALUE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SILU_ENABLE  = 3'd5;

	localparam logic [63:0] EXP_STEP = 64'd4034748383;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_ADD,
		ST_ROUND,
		ST_SILU,
		ST_EMIT
	} state_t;

	typedef logic [255:0][SIG_W-1:0] sig_table_t;

	// restoring long division, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] dvs);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], num[i]};
			if (r >= {1'b0, dvs}) begin
				r = r - {1'b0, dvs};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid at the lower edge of each 1/16 bin over [-8,8), unsigned Q0.16
	function automatic sig_table_t build_sig_table();
		sig_table_t t;
		logic [63:0] p;
		logic [63:0] den;
		logic [63:0] s;
		logic [16:0] neg;
		t = '0;
		p = 64'd1 << 32;
		for (int k = 0; k <= 128; k++) begin
			den = (64'd1 << 32) + p;
			s = udiv64((64'd1 << 48) + (den >> 1), den);
			if (k < 128) begin
				t[128 + k] = s[SIG_W-1:0];
			end
			if (k >= 1) begin
				neg = 17'h10000 - s[16:0];
				t[128 - k] = neg[SIG_W-1:0];
			end
			p = (p * EXP_STEP + (64'd1 << 31)) >> 32;
		end
		return t;
	endfunction

	localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage
`default_nettype wire

/* hw/rtl/causal_conv1d_silu_filter_top.sv */
// Causal depthwise conv1d with optional SiLU, one channel.
// Input channel: src_valid / src_stall carry sample_in (Q4.12) and restart.
// A beat is taken when src_valid is high and src_stall low. restart clears
// the three-sample history before the beat's sample is used.
// Output channel: dst_valid / dst_stall carry sample_out (Q4.12), one beat
// per input beat, held in an output register until taken.
// Config: cfg_we writes cfg_data into register cfg_idx (0..3 taps oldest to
// current, 4 bias, 5 SiLU enable); other indices are ignored. Write only
// when idle.
// Datapath: one 17x17 multiplier is shared by all taps and the SiLU scale.
// After a beat is taken the block works a MAC step per tap, one add, one
// round, one SiLU multiply when enabled and one emit step. The result is
// loaded into the output register in the emit step, and a new beat is taken
// only once the block has gone back to idle after that emit step.
// src_stall is high while an item is being worked on. If dst_stall holds a
// previous result, the emit step waits until the output register frees.
// Reset: history cleared, taps and bias zero, SiLU enabled, no result pending.
`default_nettype none
module causal_conv1d_silu_filter_top
	import cc1s_pkg::*;
#(
	parameter int TAPS = TAPS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         src_valid,
	output logic                              src_stall,
	input  wire logic signed [SAMPLE_W-1:0]   sample_in,
	input  wire logic                         restart,
	output logic                              dst_valid,
	input  wire logic                         dst_stall,
	output logic signed [SAMPLE_W-1:0]        sample_out,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

	state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] tap_q [WIN_DEPTH];
	logic signed [SAMPLE_W-1:0] bias_q;
	logic                       silu_q;
	logic signed [SAMPLE_W-1:0] win_q [WIN_DEPTH];

	logic [CNT_W-1:0]           cnt_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic                       dst_valid_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	logic                       accept;
	logic                       out_free;
	logic                       out_load;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic signed [ACC_W-1:0]    rnd_sum;
	logic signed [ACC_W-15:0]   rnd_y;
	logic signed [SAMPLE_W-1:0] sat_y;
	logic [7:0]                 sig_idx;
	logic signed [PROD_W-1:0]   scl_sum;
	logic signed [SAMPLE_W-1:0] result;
	logic [WIN_IW-1:0]          tap_sel;

	assign accept    = src_valid && !src_stall;
	assign out_free  = !dst_valid_q || !dst_stall;
	assign dst_valid = dst_valid_q;
	assign sample_out = sample_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		src_stall = 1'b1;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				src_stall = 1'b0;
				if (src_valid) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (cnt_q == CNT_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD:   state_d = ST_ROUND;
			ST_ROUND: state_d = silu_q ? ST_SILU : ST_EMIT;
			ST_SILU:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// shared multiplier
	assign tap_sel = WIN_IW'(cnt_q);
	assign sig_idx = {~y_q[15], y_q[14:8]};
	assign mul_a = (state_q == ST_SILU) ? MUL_W'(y_q) : MUL_W'(tap_q[tap_sel]);
	assign mul_b = (state_q == ST_SILU) ? $signed({1'b0, SIG_TABLE[sig_idx]})
	                                    : MUL_W'(win_q[tap_sel]);
	assign mul_p = mul_a * mul_b;

	assign rnd_sum = acc_q + ACC_W'(8192);
	assign rnd_y   = rnd_sum[ACC_W-1:14];

	always_comb begin
		if (rnd_y > (ACC_W-14)'(32767)) begin
			sat_y = 16'sh7fff;
		end else if (rnd_y < -(ACC_W-14)'(32768)) begin
			sat_y = 16'sh8000;
		end else begin
			sat_y = rnd_y[SAMPLE_W-1:0];
		end
	end

	assign scl_sum = prod_q + PROD_W'(32768);
	assign result  = silu_q ? scl_sum[31:16] : y_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				tap_q[i] <= '0;
			end
			bias_q <= '0;
			silu_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TAP_OLDEST:   tap_q[3] <= cfg_data;
				REG_TAP_OLDER:    tap_q[2] <= cfg_data;
				REG_TAP_PREVIOUS: tap_q[1] <= cfg_data;
				REG_TAP_CURRENT:  tap_q[0] <= cfg_data;
				REG_BIAS_VALUE:   bias_q   <= cfg_data;
				REG_SILU_ENABLE:  silu_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sample window: entry 0 current, entries 1..3 history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (accept) begin
			win_q[0] <= sample_in;
			for (int i = 1; i < WIN_DEPTH; i++) begin
				win_q[i] <= restart ? '0 : win_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == ST_MAC) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= ACC_W'(bias_q) <<< 14;
		end else if ((state_q == ST_MAC && cnt_q != '0) || state_q == ST_ADD) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
		if (state_q == ST_MAC || state_q == ST_SILU) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_ROUND) begin
			y_q <= sat_y;
		end
		if (out_load) begin
			sample_out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (out_load) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/cc1s_checker.sv */
`default_nettype none
module cc1s_checker
	import cc1s_pkg::*;
(
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       src_valid,
	input wire logic                       src_stall,
	input wire logic                       dst_valid,
	input wire logic                       dst_stall,
	input wire logic [SAMPLE_W-1:0]        sample_out
);

	// stalled result beat holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(sample_out))
		else $error("stalled result beat changed");

	// busy after taking a beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> src_stall)
		else $error("input taken while busy");

	// no result in the cycle after acceptance
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> !$rose(dst_valid))
		else $error("result too early");

	// a new result only appears while an item is in work
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(src_stall))
		else $error("result without an item in work");

endmodule

bind causal_conv1d_silu_filter_top cc1s_checker u_cc1s_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.src_valid  (src_valid),
	.src_stall  (src_stall),
	.dst_valid  (dst_valid),
	.dst_stall  (dst_stall),
	.sample_out (sample_out)
);
`default_nettype wire

/* tb/sv/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cc1s_pkg::*;

	localparam int N_TAPS          = TAPS_DEF;
	localparam int N_PHASES        = 8;
	localparam int BEATS_PER_PHASE = 250;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int N_DIRECTED      = 24;

	// indices with no register behind them; IDX_NONE fills the idx field of beat rows
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] IDX_NONE     = 3'd0;

	typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [15:0]            value;
		logic                   restart;
		logic                   known;
		logic [15:0]            want;
	} row_t;

	// beat rows: value is the sample; cfg rows: value is the register data
	localparam row_t DIRECTED [N_DIRECTED] = '{
		'{ROW_BEAT, IDX_NONE,         16'h7FFF, 1'b0, 1'b1, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'h8000, 1'b0, 1'b1, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'hFFFF, 1'b1, 1'b1, 16'h0000},
		'{ROW_CFG,  REG_TAP_CURRENT,  16'h4000, 1'b0, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_SILU_ENABLE,  16'hFFFE, 1'b0, 1'b0, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
		'{ROW_BEAT, IDX_NONE,         16'h8000, 1'b0, 1'b1, 16'h8000},
		'{ROW_BEAT, IDX_NONE,         16'h04D2, 1'b1, 1'b1, 16'h04D2},
		'{ROW_CFG,  REG_SPARE_LO,     16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_SPARE_HI,     16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
		'{ROW_CFG,  REG_TAP_OLDEST,   16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_TAP_OLDER,    16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_TAP_PREVIOUS, 16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_TAP_CURRENT,  16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_BIAS_VALUE,   16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_SILU_ENABLE,  16'h0001, 1'b0, 1'b0, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'h7FFF, 1'b1, 1'b0, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'h7FFF, 1'b0, 1'b0, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_CFG,  REG_BIAS_VALUE,   16'h8000, 1'b0, 1'b0, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'hF800, 1'b1, 1'b0, 16'h0000},
		'{ROW_BEAT, IDX_NONE,         16'h012C, 1'b0, 1'b0, 16'h0000}
	};

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        src_valid  = 1'b0;
	logic                        src_stall;
	logic signed [SAMPLE_W-1:0]  sample_in  = '0;
	logic                        restart    = 1'b0;
	logic                        dst_valid;
	logic                        dst_stall  = 1'b0;
	logic signed [SAMPLE_W-1:0]  sample_out;
	logic                        cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_idx    = '0;
	logic [CFG_DATA_W-1:0]       cfg_data   = '0;

	// shadow settings; weight[k] applies to the sample k steps back
	logic signed [15:0] weight [4] = '{default: '0};
	logic signed [15:0] bias       = '0;
	logic               silu_on    = 1'b1;
	logic signed [15:0] past [3]   = '{default: '0};
	int unsigned        sigmoid_lut [256];

	logic signed [15:0] expected_out [$];
	logic signed [15:0] oldest_out;
	bit                 steady   = 1'b0;
	int                 n_errors = 0;
	int                 n_cycles = 0;

	causal_conv1d_silu_filter_top #(.TAPS(N_TAPS)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.sample_in  (sample_in),
		.restart    (restart),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// sigmoid at the lower edge of each 1/16 bin, exp(-1/16) stepped in Q0.32
	function automatic void fill_sigmoid_lut();
		longint unsigned decay;
		longint unsigned den;
		longint unsigned sig;
		decay = 64'd1 << 32;
		for (int k = 0; k <= 128; k++) begin
			den = (64'd1 << 32) + decay;
			sig = ((64'd1 << 48) + den / 2) / den;
			if (k < 128) begin
				sigmoid_lut[128 + k] = int'(sig);
			end
			if (k >= 1) begin
				sigmoid_lut[128 - k] = 65536 - int'(sig);
			end
			decay = (decay * 64'd4034748383 + (64'd1 << 31)) >> 32;
		end
	endfunction

	function automatic logic signed [15:0] conv_silu_predict(logic signed [15:0] x,
			logic clear);
		longint acc;
		longint scaled;
		logic signed [15:0] y;
		logic [7:0] bin;
		if (clear) begin
			past = '{default: '0};
		end
		acc = longint'(weight[0]) * longint'(x);
		for (int j = 1; j < N_TAPS; j++) begin
			acc += longint'(weight[j]) * longint'(past[j-1]);
		end
		acc += longint'(bias) * 64'sd16384;
		acc = (acc + 64'sd8192) >>> 14;
		if (acc > 64'sd32767) begin
			acc = 64'sd32767;
		end else if (acc < -64'sd32768) begin
			acc = -64'sd32768;
		end
		y = acc[15:0];
		if (silu_on) begin
			bin = y[15:8] ^ 8'h80;
			scaled = (longint'(y) * longint'(sigmoid_lut[bin]) + 64'sd32768) >>> 16;
			y = scaled[15:0];
		end
		past[2] = past[1];
		past[1] = past[0];
		past[0] = x;
		return y;
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4: return 16'($urandom_range(0, 8191)) - 16'd4096;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
			1, 2, 3: return 16'($urandom_range(0, 8191)) - 16'd4096;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		case (idx)
			REG_TAP_OLDEST:   weight[3] = data;
			REG_TAP_OLDER:    weight[2] = data;
			REG_TAP_PREVIOUS: weight[1] = data;
			REG_TAP_CURRENT:  weight[0] = data;
			REG_BIAS_VALUE:   bias = data;
			REG_SILU_ENABLE:  silu_on = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// drop valid and let every outstanding result drain
	task automatic wait_for_results();
		src_valid <= 1'b0;
		while (expected_out.size() != 0) begin
			@(negedge clk);
		end
		@(posedge clk);
	endtask

	task automatic send_beat(input logic [15:0] s, input logic clear, input logic known,
			input logic [15:0] want);
		logic signed [15:0] predicted;
		while (!steady && $urandom_range(0, 99) < 7) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		sample_in <= s;
		restart   <= clear;
		do begin
			@(posedge clk);
		end while (src_stall);
		predicted = conv_silu_predict(s, clear);
		if (known) begin
			predicted = want;
		end
		expected_out = {expected_out, predicted};
	endtask

	task automatic load_random_settings();
		wait_for_results();
		write_reg(REG_TAP_OLDEST, pick_weight());
		write_reg(REG_TAP_OLDER, pick_weight());
		write_reg(REG_TAP_PREVIOUS, pick_weight());
		write_reg(REG_TAP_CURRENT, pick_weight());
		write_reg(REG_BIAS_VALUE, pick_weight());
		write_reg(REG_SILU_ENABLE, 16'($urandom));
		if ($urandom_range(0, 1) != 0) begin
			write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
				16'($urandom));
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		dst_stall <= !steady && ($urandom_range(0, 99) < 7);
	end

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_out.size() == 0) begin
				$error("sample_out: no result pending, got %0d", sample_out);
				n_errors++;
			end else begin
				oldest_out = expected_out.pop_front();
				if (sample_out !== oldest_out) begin
					$error("sample_out: expected %0d, got %0d", oldest_out, sample_out);
					n_errors++;
				end
			end
		end
	end

	initial begin
		fill_sigmoid_lut();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				if (i == 0 || DIRECTED[i-1].kind == ROW_BEAT) begin
					wait_for_results();
				end
				write_reg(DIRECTED[i].idx, DIRECTED[i].value);
			end else begin
				if (i > 0 && DIRECTED[i-1].kind == ROW_CFG) begin
					cfg_we <= 1'b0;
				end
				send_beat(DIRECTED[i].value, DIRECTED[i].restart, DIRECTED[i].known,
					DIRECTED[i].want);
			end
		end

		// phase 2 runs with no idling on either side
		for (int ph = 0; ph < N_PHASES; ph++) begin
			steady <= (ph == 2);
			load_random_settings();
			for (int n = 0; n < BEATS_PER_PHASE; n++) begin
				if (ph == 3 && n == BEATS_PER_PHASE / 2) begin
					wait_for_results();
				end
				send_beat(pick_sample(), $urandom_range(0, 15) == 0, 1'b0, 16'h0000);
			end
		end

		wait_for_results();
		repeat (16) @(posedge clk);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
